>>> design/slbp_pkg.sv
// ----------------------------------------------------------------------------
// slbp_pkg
// Shared types, constants and pattern functions for the status LED blink
// pattern generator.
// ----------------------------------------------------------------------------
package slbp_pkg;

	// Tick word from the host side
	typedef struct packed {
		logic [9:0] advance_ms;
		logic [2:0] display_mode;
		logic       error_request;
	} slbp_in_t;

	// LED word towards the pin driver
	typedef struct packed {
		logic led_lit;
		logic pin_level;
	} slbp_out_t;

	// Display mode codes
	localparam logic [2:0] MODE_INIT         = 3'd0;
	localparam logic [2:0] MODE_DISCOVERABLE = 3'd1;
	localparam logic [2:0] MODE_CONNECTED    = 3'd2;
	localparam logic [2:0] MODE_STREAMING    = 3'd3;
	localparam logic [2:0] MODE_ERROR        = 3'd4;
	localparam logic [2:0] MODE_NONE_SEEN    = 3'd7;

	// Timing in milliseconds
	localparam int unsigned PHASE_WRAP_MS = 4000;
	localparam int unsigned OVL_LEN_MS    = 480;

	// Phase timer width
	localparam int unsigned PHASE_W = 12;

	// Lit for 80 ms of every 160 ms: floor(t/80) even.
	// t/80 = (t>>4)/5, and x/5 == (x*205)>>10 for x below 1024.
	function automatic logic flash_on(input logic [PHASE_W-1:0] t);
		logic [17:0] prod;
		prod = 18'(t[11:4]) * 18'd205;
		return ~prod[10];
	endfunction

	// Lit for 100 ms of every 200 ms: floor(t/100) even.
	// t/100 = (t>>2)/25, and x/25 == (x*41)>>10 for x below 1000.
	function automatic logic init_on(input logic [PHASE_W-1:0] t);
		logic [16:0] prod;
		prod = 17'(t[11:2]) * 17'd41;
		return ~prod[10];
	endfunction

	// Lit for the first 500 ms of every second (phase stays below 4000)
	function automatic logic slow_on(input logic [PHASE_W-1:0] t);
		return (t < 12'd500) ||
			(t >= 12'd1000 && t < 12'd1500) ||
			(t >= 12'd2000 && t < 12'd2500) ||
			(t >= 12'd3000 && t < 12'd3500);
	endfunction

	// Lit for the first 920 ms of every second
	function automatic logic stream_on(input logic [PHASE_W-1:0] t);
		return !((t >= 12'd920  && t < 12'd1000) ||
			(t >= 12'd1920 && t < 12'd2000) ||
			(t >= 12'd2920 && t < 12'd3000) ||
			(t >= 12'd3920));
	endfunction

	// Normal mode pattern; unknown codes leave the LED dark
	function automatic logic normal_on(input logic [2:0] mode, input logic [PHASE_W-1:0] t);
		logic res;
		case (mode)
			MODE_INIT:         res = init_on(t);
			MODE_DISCOVERABLE: res = slow_on(t);
			MODE_CONNECTED:    res = 1'b1;
			MODE_STREAMING:    res = stream_on(t);
			MODE_ERROR:        res = flash_on(t);
			default:           res = 1'b0;
		endcase
		return res;
	endfunction

endpackage

>>> design/status_led_blink_pattern.sv
// ----------------------------------------------------------------------------
// status_led_blink_pattern
// Status LED blink pattern generator with error-flash overlay and
// configurable active level.
// ----------------------------------------------------------------------------
// One tick word in gives one LED word out. The block takes a tick word in
// every cycle unless tick_stall is high; each word passes through the input
// register, where the phase timer and overlay logic work on it, and then
// sits in the result register until taken, so the throughput is one word per
// cycle, held back only by stall on the LED side. The active-level
// register is written through cfg_valid/cfg_ready (always ready) and should
// be changed only while no word is in flight. The phase timer wraps at
// 4000 ms.
module status_led_blink_pattern (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick_valid,
	output logic                tick_stall,
	input  slbp_pkg::slbp_in_t  tick_word,
	output logic                led_valid,
	input  logic                led_stall,
	output slbp_pkg::slbp_out_t led_word,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data
);

	logic                         active_high_q;
	logic                         valid_s1;
	slbp_pkg::slbp_in_t           tick_s1;
	logic                         led_valid_q;
	slbp_pkg::slbp_out_t          led_q;
	logic                         out_free;
	logic                         fire;
	logic                         lit;
	logic [slbp_pkg::PHASE_W-1:0] phase;

	// Handshake: stage 1 moves on when the result register is free or drains
	assign out_free   = !led_valid_q || !led_stall;
	assign fire       = valid_s1 && out_free;
	assign tick_stall = valid_s1 && !out_free;
	assign cfg_ready  = 1'b1;

	// Active-level register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_high_q <= 1'b1;
		end else if (cfg_valid) begin
			active_high_q <= cfg_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!tick_stall) begin
			valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && !tick_stall) begin
			tick_s1 <= tick_word;
		end
	end

	slbp_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.tick    (tick_s1),
		.led_lit (lit),
		.phase   (phase)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_valid_q <= 1'b0;
		end else if (out_free) begin
			led_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			led_q.led_lit   <= lit;
			led_q.pin_level <= lit ~^ active_high_q;
		end
	end

	assign led_valid = led_valid_q;
	assign led_word  = led_q;

	// Phase timer never reaches the wrap value
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase < slbp_pkg::PHASE_W'(slbp_pkg::PHASE_WRAP_MS))
		else $error("phase timer out of range");

	// Input stall only when a word waits behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		tick_stall |-> (valid_s1 && led_valid_q && led_stall))
		else $error("input stalled without a blocked result");

	// A word leaving stage 1 shows up as a result next cycle
	a_word_moves: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> led_valid)
		else $error("word lost between stages");

endmodule

>>> design/slbp_step.sv
// ----------------------------------------------------------------------------
// slbp_step
// Pattern state (phase timer, last mode, overlay flag) and the single-pass
// next-state and LED logic for one tick word.
// ----------------------------------------------------------------------------
module slbp_step (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  slbp_pkg::slbp_in_t            tick,
	output logic                          led_lit,
	output logic [slbp_pkg::PHASE_W-1:0]  phase
);

	logic [slbp_pkg::PHASE_W-1:0] phase_q;
	logic [2:0]                   last_mode_q;
	logic                         overlay_q;

	logic [slbp_pkg::PHASE_W:0]   sum;
	logic [slbp_pkg::PHASE_W-1:0] wrapped;
	logic                         restart;
	logic [slbp_pkg::PHASE_W-1:0] ph;
	logic                         ovl;
	logic                         ovl_run;
	logic [slbp_pkg::PHASE_W-1:0] phase_d;

	// Advance, wrap at the common period, restart on mode change or error
	always_comb begin
		sum     = {1'b0, phase_q} + (slbp_pkg::PHASE_W+1)'(tick.advance_ms);
		wrapped = (sum >= (slbp_pkg::PHASE_W+1)'(slbp_pkg::PHASE_WRAP_MS)) ?
			slbp_pkg::PHASE_W'(sum - (slbp_pkg::PHASE_W+1)'(slbp_pkg::PHASE_WRAP_MS)) :
			sum[slbp_pkg::PHASE_W-1:0];
		restart = (tick.display_mode != last_mode_q) || tick.error_request;
		ph      = restart ? '0 : wrapped;
		ovl     = overlay_q | tick.error_request;
		ovl_run = ovl && (ph < slbp_pkg::PHASE_W'(slbp_pkg::OVL_LEN_MS));
		// overlay over: phase restarts and the normal pattern shows at once
		phase_d = (ovl && !ovl_run) ? '0 : ph;
		led_lit = ovl_run ? slbp_pkg::flash_on(ph) :
			slbp_pkg::normal_on(tick.display_mode, phase_d);
	end

	// State update once per tick word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			last_mode_q <= slbp_pkg::MODE_NONE_SEEN;
			overlay_q   <= 1'b0;
		end else if (fire) begin
			phase_q     <= phase_d;
			last_mode_q <= tick.display_mode;
			overlay_q   <= ovl_run;
		end
	end

	assign phase = phase_q;

endmodule

>>> tb/tb_status_led_blink_pattern.sv
// ----------------------------------------------------------------------------
// tb_status_led_blink_pattern
// Self-checking bench for the status LED blink pattern generator.
// ----------------------------------------------------------------------------
// A short directed run walks the mode codes, the error-flash overlay, the
// phase wrap and the unused codes. Random tick words follow in five phases,
// each under its own active level. Every LED word is compared with a local
// model of the phase timer, mode tracking and overlay. Both sides idle in
// random bursts, except for a quiet stretch and the last phase.
// ----------------------------------------------------------------------------
module tb_status_led_blink_pattern;

	timeunit 1ns;
	timeprecision 1ps;

	// Codes and timings that the package does not name
	localparam logic [2:0] MODE_OFF   = 3'd5;
	localparam logic [2:0] MODE_SPARE = 3'd6;
	localparam int unsigned FLASH_PERIOD_MS = 160;
	localparam int unsigned FLASH_LIT_MS    = 80;
	localparam int unsigned INIT_PERIOD_MS  = 200;
	localparam int unsigned INIT_LIT_MS     = 100;
	localparam int unsigned SLOW_PERIOD_MS  = 1000;
	localparam int unsigned SLOW_LIT_MS     = 500;
	localparam int unsigned STREAM_LIT_MS   = 920;

	localparam int WARMUP_N       = 25;
	localparam int PHASE_N        = 5;
	localparam int TICKS_PER_PHASE = 190;
	localparam int WATCHDOG_LIMIT = 2000;

	// One directed row: tick fields, and a typed LED word where marked
	typedef struct packed {
		logic [9:0]          adv;
		logic [2:0]          mode;
		logic                req;
		logic                typed;
		slbp_pkg::slbp_out_t want;
	} warmup_row_t;

	// Reset active level is high, so typed pin levels equal the lit flag
	warmup_row_t warmup_rows [WARMUP_N] = '{
		'{10'd0,    slbp_pkg::MODE_NONE_SEEN,    1'b0, 1'b1, '{1'b0, 1'b0}},
		'{10'd1023, slbp_pkg::MODE_NONE_SEEN,    1'b0, 1'b1, '{1'b0, 1'b0}},
		'{10'd0,    slbp_pkg::MODE_CONNECTED,    1'b0, 1'b1, '{1'b1, 1'b1}},
		'{10'd1023, slbp_pkg::MODE_CONNECTED,    1'b0, 1'b1, '{1'b1, 1'b1}},
		'{10'd1023, slbp_pkg::MODE_CONNECTED,    1'b1, 1'b0, '{1'b0, 1'b0}},
		'{10'd100,  slbp_pkg::MODE_CONNECTED,    1'b0, 1'b0, '{1'b0, 1'b0}},
		'{10'd200,  slbp_pkg::MODE_CONNECTED,    1'b1, 1'b0, '{1'b0, 1'b0}},
		'{10'd170,  slbp_pkg::MODE_DISCOVERABLE, 1'b0, 1'b0, '{1'b0, 1'b0}},
		'{10'd479,  slbp_pkg::MODE_DISCOVERABLE, 1'b0, 1'b0, '{1'b0, 1'b0}},
		'{10'd1,    slbp_pkg::MODE_DISCOVERABLE, 1'b0, 1'b0, '{1'b0, 1'b0}},
		'{10'd700,  slbp_pkg::MODE_DISCOVERABLE, 1'b0, 1'b0, '{1'b0, 1'b0}},
		'{10'd0,    slbp_pkg::MODE_INIT,         1'b0, 1'b0, '{1'b0, 1'b0}},
		'{10'd150,  slbp_pkg::MODE_INIT,         1'b0, 1'b0, '{1'b0, 1'b0}},
		'{10'd0,    slbp_pkg::MODE_STREAMING,    1'b0, 1'b0, '{1'b0, 1'b0}},
		'{10'd930,  slbp_pkg::MODE_STREAMING,    1'b0, 1'b0, '{1'b0, 1'b0}},
		'{10'd1023, slbp_pkg::MODE_STREAMING,    1'b0, 1'b0, '{1'b0, 1'b0}},
		'{10'd1023, slbp_pkg::MODE_STREAMING,    1'b0, 1'b0, '{1'b0, 1'b0}},
		'{10'd1023, slbp_pkg::MODE_STREAMING,    1'b0, 1'b0, '{1'b0, 1'b0}},
		'{10'd1,    slbp_pkg::MODE_STREAMING,    1'b0, 1'b0, '{1'b0, 1'b0}},
		'{10'd0,    slbp_pkg::MODE_ERROR,        1'b0, 1'b0, '{1'b0, 1'b0}},
		'{10'd80,   slbp_pkg::MODE_ERROR,        1'b0, 1'b0, '{1'b0, 1'b0}},
		'{10'd0,    MODE_OFF,                    1'b0, 1'b1, '{1'b0, 1'b0}},
		'{10'd1023, MODE_SPARE,                  1'b0, 1'b1, '{1'b0, 1'b0}},
		'{10'd1023, slbp_pkg::MODE_NONE_SEEN,    1'b1, 1'b0, '{1'b0, 1'b0}},
		'{10'd1023, slbp_pkg::MODE_NONE_SEEN,    1'b0, 1'b0, '{1'b0, 1'b0}}
	};

	// Clock, reset and block inputs, all known from time zero
	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                tick_valid = 1'b0;
	slbp_pkg::slbp_in_t  tick_word  = '0;
	logic                led_stall  = 1'b0;
	logic                cfg_valid  = 1'b0;
	logic                cfg_data   = 1'b0;
	logic                tick_stall;
	logic                led_valid;
	slbp_pkg::slbp_out_t led_word;
	logic                cfg_ready;

	// Model state
	logic [11:0] blink_phase   = '0;
	logic [2:0]  shown_mode    = slbp_pkg::MODE_NONE_SEEN;
	logic        flash_overlay = 1'b0;
	logic        lit_polarity  = 1'b1;

	slbp_pkg::slbp_out_t led_due [$];
	slbp_pkg::slbp_out_t due_word;
	int          faults    = 0;
	int          stall_run = 0;
	logic        idle_en   = 1'b0;
	logic [2:0]  roam_mode = slbp_pkg::MODE_CONNECTED;

	status_led_blink_pattern i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_stall (tick_stall),
		.tick_word  (tick_word),
		.led_valid  (led_valid),
		.led_stall  (led_stall),
		.led_word   (led_word),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Phase timer, mode tracking and overlay for one tick word
	function automatic slbp_pkg::slbp_out_t next_led(input slbp_pkg::slbp_in_t w);
		int unsigned         t;
		logic                lit;
		slbp_pkg::slbp_out_t res;
		t = (int'(blink_phase) + int'(w.advance_ms)) % slbp_pkg::PHASE_WRAP_MS;
		if (w.display_mode != shown_mode) begin
			shown_mode = w.display_mode;
			t = 0;
		end
		if (w.error_request) begin
			flash_overlay = 1'b1;
			t = 0;
		end
		lit = 1'b0;
		if (flash_overlay) begin
			if (t < slbp_pkg::OVL_LEN_MS) begin
				lit = (t % FLASH_PERIOD_MS) < FLASH_LIT_MS;
			end else begin
				flash_overlay = 1'b0;
				t = 0;
			end
		end
		if (!flash_overlay) begin
			case (w.display_mode)
				slbp_pkg::MODE_INIT:         lit = (t % INIT_PERIOD_MS) < INIT_LIT_MS;
				slbp_pkg::MODE_DISCOVERABLE: lit = (t % SLOW_PERIOD_MS) < SLOW_LIT_MS;
				slbp_pkg::MODE_CONNECTED:    lit = 1'b1;
				slbp_pkg::MODE_STREAMING:    lit = (t % SLOW_PERIOD_MS) < STREAM_LIT_MS;
				slbp_pkg::MODE_ERROR:        lit = (t % FLASH_PERIOD_MS) < FLASH_LIT_MS;
				default:                     lit = 1'b0;
			endcase
		end
		blink_phase   = 12'(t);
		res.led_lit   = lit;
		res.pin_level = lit ? lit_polarity : ~lit_polarity;
		return res;
	endfunction

	// Random tick: mostly a held mode with short advances, rare changes and flashes
	function automatic slbp_pkg::slbp_in_t roam_tick();
		slbp_pkg::slbp_in_t w;
		int                 r;
		if ($urandom_range(0, 99) < 7) begin
			if ($urandom_range(0, 4) != 0)
				roam_mode = 3'($urandom_range(0, 4));
			else
				roam_mode = 3'($urandom_range(5, 7));
		end
		w.display_mode = roam_mode;
		r = $urandom_range(0, 99);
		if (r < 60)
			w.advance_ms = 10'($urandom_range(0, 120));
		else if (r < 90)
			w.advance_ms = 10'($urandom_range(0, 1023));
		else if (r < 95)
			w.advance_ms = 10'd0;
		else
			w.advance_ms = 10'd1023;
		w.error_request = ($urandom_range(0, 24) == 0);
		return w;
	endfunction

	// Offer one tick word, with a random gap in front when idling is on
	task automatic send_tick(input slbp_pkg::slbp_in_t w);
		if (idle_en && $urandom_range(0, 5) == 0) begin
			tick_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		tick_valid <= 1'b1;
		tick_word  <= w;
		@(posedge clk);
		while (tick_stall) @(posedge clk);
	endtask

	// Active-level write; the caller has drained the block first
	task automatic write_level(input logic v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid    <= 1'b0;
		lit_polarity  = v;
	endtask

	// LED side stall bursts, cut short when idling stops
	always @(posedge clk) begin
		if (!idle_en) begin
			led_stall <= 1'b0;
			stall_run <= 0;
		end else if (stall_run != 0) begin
			stall_run <= stall_run - 1;
		end else if ($urandom_range(0, 9) == 0) begin
			led_stall <= 1'b1;
			stall_run <= $urandom_range(0, 18);
		end else begin
			led_stall <= 1'b0;
		end
	end

	// Compare each LED word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && led_valid && !led_stall) begin
			if (led_due.size() == 0) begin
				$display("%0t: unexpected LED word, actual lit %0b pin %0b",
					$time, led_word.led_lit, led_word.pin_level);
				faults++;
			end else begin
				due_word = led_due.pop_front();
				if (led_word.led_lit !== due_word.led_lit) begin
					$display("%0t: led_lit expected %0b actual %0b",
						$time, due_word.led_lit, led_word.led_lit);
					faults++;
				end
				if (led_word.pin_level !== due_word.pin_level) begin
					$display("%0t: pin_level expected %0b actual %0b",
						$time, due_word.pin_level, led_word.pin_level);
					faults++;
				end
			end
		end
	end

	// Watchdog: too many cycles without any word moving
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((tick_valid && !tick_stall) || (led_valid && !led_stall) ||
				(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Stimulus
	initial begin : stimulus
		slbp_pkg::slbp_out_t predicted;
		logic                level_plan [PHASE_N];
		slbp_pkg::slbp_in_t  w;
		repeat (5) @(posedge clk);
		arst_n  <= 1'b1;
		idle_en <= 1'b1;
		@(posedge clk);

		// Directed rows under the reset active level
		foreach (warmup_rows[i]) begin
			w.advance_ms    = warmup_rows[i].adv;
			w.display_mode  = warmup_rows[i].mode;
			w.error_request = warmup_rows[i].req;
			send_tick(w);
			predicted = next_led(w);
			led_due.push_back(warmup_rows[i].typed ? warmup_rows[i].want : predicted);
		end

		// Random phases, each behind an active-level write
		level_plan = '{1'b0, 1'b1, 1'b0, 1'($urandom_range(0, 1)), 1'b1};
		for (int p = 0; p < PHASE_N; p++) begin
			tick_valid <= 1'b0;
			while (led_due.size() != 0) @(posedge clk);
			idle_en <= (p != 1) && (p != PHASE_N - 1);
			write_level(level_plan[p]);
			for (int n = 0; n < TICKS_PER_PHASE; n++) begin
				w = roam_tick();
				send_tick(w);
				led_due.push_back(next_led(w));
			end
		end

		// Drain and let the pipeline settle
		tick_valid <= 1'b0;
		while (led_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (faults == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
